/* hw/rtl/isort_pkg.sv */
// Shared types and constants for the insertion sorter.
`timescale 1ns / 1ps

package isort_pkg;

    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;    // insert the broadcast value
        logic shift;  // move every entry one place toward cell 0
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage

/* hw/rtl/insertion_sorter_top.sv */
// Top level of the insertion sorter: cell chain, fill/drain control, output register.
`timescale 1ns / 1ps

// Insertion sorter. Signed 32-bit values enter one per cycle while filling and
// are placed in sorted order in a chain of CAPACITY cells; every cell compares
// against the new value in parallel, so insertion cost does not grow with fill.
// The value flagged with tlast is inserted and then the whole set is emitted in
// ascending order, one result per cycle while the sink accepts, with tlast on
// the greatest value and tuser set on every result if any value of the set was
// dropped because the chain was full. Input is held off while the chain shifts
// its contents out through cell 0, and the next set starts empty.
module insertion_sorter_top
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] value
    input  logic        s_axis_tlast,  // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] sorted_value
    output logic        m_axis_tlast,  // last_result
    output logic        m_axis_tuser   // [0] dropped
);

    isort_pkg::state_t     state_reg;
    isort_pkg::state_t     state_next;
    logic                  overflow_reg;
    logic                  overflow_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    isort_pkg::value_t     out_val_reg;
    logic                  out_last_reg;
    logic                  out_drop_reg;
    isort_pkg::cell_ctrl_t ctrl;

    isort_pkg::value_t     cell_val   [CAPACITY];
    logic [CAPACITY-1:0]   cell_valid;
    logic [CAPACITY-1:0]   cell_gt;

    logic in_req;
    logic full;
    logic drain_step;

    assign s_axis_tready = (state_reg == isort_pkg::ST_FILL);
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign full          = cell_valid[CAPACITY-1];
    assign drain_step    = (state_reg == isort_pkg::ST_DRAIN)
                           && (!out_valid_reg || m_axis_tready);

    // Fields in declaration order: ins, shift.
    assign ctrl = {in_req && !full, drain_step};

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            isort_pkg::value_t lv;
            logic              lvalid;
            logic              lgt;
            isort_pkg::value_t rv;
            logic              rvalid;

            if (i == 0)
            begin : g_head
                assign lv     = '0;
                assign lvalid = 1'b1;
                assign lgt    = 1'b0;
            end
            else
            begin : g_body
                assign lv     = cell_val[i-1];
                assign lvalid = cell_valid[i-1];
                assign lgt    = cell_gt[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign rv     = '0;
                assign rvalid = 1'b0;
            end
            else
            begin : g_inner
                assign rv     = cell_val[i+1];
                assign rvalid = cell_valid[i+1];
            end

            isort_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .x           (s_axis_tdata),
                .left_val    (lv),
                .left_valid  (lvalid),
                .left_gt     (lgt),
                .right_val   (rv),
                .right_valid (rvalid),
                .val         (cell_val[i]),
                .valid       (cell_valid[i]),
                .gt          (cell_gt[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        overflow_next  = overflow_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            isort_pkg::ST_FILL:
            begin
                if (in_req)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        state_next = isort_pkg::ST_DRAIN;
                    end
                end
            end
            isort_pkg::ST_DRAIN:
            begin
                if (drain_step)
                begin
                    out_valid_next = 1'b1;
                    // Cell 1 empty means cell 0 holds the final entry of the set.
                    if (!cell_valid[1])
                    begin
                        state_next    = isort_pkg::ST_FILL;
                        overflow_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = isort_pkg::ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isort_pkg::ST_FILL;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain_step)
        begin
            out_val_reg  <= cell_val[0];
            out_last_reg <= !cell_valid[1];
            out_drop_reg <= overflow_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_val_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_drop_reg;

endmodule

/* hw/rtl/isort_cell.sv */
// One cell of the sorting chain: holds one entry and trades with its neighbors.
`timescale 1ns / 1ps

module isort_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  isort_pkg::cell_ctrl_t ctrl,
    input  isort_pkg::value_t     x,
    input  isort_pkg::value_t     left_val,
    input  logic                  left_valid,
    input  logic                  left_gt,
    input  isort_pkg::value_t     right_val,
    input  logic                  right_valid,
    output isort_pkg::value_t     val,
    output logic                  valid,
    output logic                  gt
);

    isort_pkg::value_t val_reg;
    isort_pkg::value_t val_next;
    logic              valid_reg;
    logic              valid_next;

    // Strictly greater, so an equal value lands after the entries already held.
    assign gt    = valid_reg && (val_reg > x);
    assign val   = val_reg;
    assign valid = valid_reg;

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            val_next   = right_val;
            valid_next = right_valid;
        end
        else if (ctrl.ins)
        begin
            if (left_gt)
            begin
                val_next   = left_val;
                valid_next = 1'b1;
            end
            else if (gt || (!valid_reg && left_valid))
            begin
                val_next   = x;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

/* hw/rtl/isort_check.sv */
// Port-level checks for the insertion sorter, bound to the top level.
`timescale 1ns / 1ps

module isort_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // A stalled result holds its value and flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // The closing request of a set stops further input until the set is out.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken right after closing request");

    // No input is taken while a run is mid-way out.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready during emission");

    // A run streams back to back and the drop flag is the same throughout.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser)))
        else $error("gap or drop flag change inside a run");

endmodule

bind insertion_sorter_top isort_check u_isort_check
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

/* sim/tb_insertion_sorter_top.sv */
// Self-checking testbench for insertion_sorter_top: random sets, sorted-output prediction.
`timescale 1ns / 1ps

module tb_insertion_sorter_top;

    localparam int CAPACITY = 64;
    localparam int PHASE_ITEMS = 105;
    localparam isort_pkg::value_t VAL_MIN = 32'sh8000_0000;
    localparam isort_pkg::value_t VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        isort_pkg::value_t value;
        logic              last_item;
        int                phase;
        bit                hold;      // wait for the previous sets to drain before sending
    } sort_req_t;

    typedef struct {
        isort_pkg::value_t value;
        logic              last_result;
        logic              dropped;
    } sorted_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // [31:0] value
    logic        s_axis_tlast = 1'b0;  // last_item
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;  // [31:0] sorted_value
    logic        m_axis_tlast;  // last_result
    logic        m_axis_tuser;  // [0] dropped

    sort_req_t         pending_values[$];
    sorted_word_t      expected_sorted[$];
    isort_pkg::value_t set_store[$];
    logic              set_overflow = 1'b0;
    bit                req_taken = 1'b0;
    int                cur_phase = 0;
    int                err_count = 0;
    int                src_idle_pct[3] = '{26, 63, 0};
    int                snk_idle_pct[3] = '{63, 26, 0};

    insertion_sorter_top #(.CAPACITY(CAPACITY)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        err_count++;
    endtask

    // Insert one value into the running set; on the closing value emit the whole set.
    task automatic sort_insert(isort_pkg::value_t v, logic fin);
        int pos;
        if (set_store.size() >= CAPACITY)
        begin
            set_overflow = 1'b1;
        end
        else
        begin
            pos = set_store.size();
            // strict compare keeps equal values in arrival order
            while (pos > 0 && set_store[pos-1] > v)
                pos--;
            set_store.insert(pos, v);
        end
        if (fin)
        begin
            foreach (set_store[k])
                expected_sorted.push_back('{set_store[k], k == set_store.size() - 1,
                                            set_overflow});
            set_store.delete();
            set_overflow = 1'b0;
        end
    endtask

    function automatic isort_pkg::value_t rand_value();
        case ($urandom_range(9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2, 3: return isort_pkg::value_t'($urandom_range(8)) - 4;  // dense range, many ties
            default: return isort_pkg::value_t'($urandom());
        endcase
    endfunction

    task automatic push_req(isort_pkg::value_t v, logic fin, int phase, bit hold);
        pending_values.push_back('{v, fin, phase, hold});
    endtask

    task automatic queue_set(int len, int phase, bit hold);
        for (int i = 0; i < len; i++)
            push_req(rand_value(), i == len - 1, phase, hold && i == 0);
    endtask

    // Check outputs first, then predict from the request taken at the same edge.
    always @(posedge clk)
    begin : check_results
        sorted_word_t exp;
        req_taken = s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_sorted.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
            end
            else
            begin
                exp = expected_sorted.pop_front();
                if (m_axis_tdata !== exp.value)
                    report_mismatch($sformatf("sorted_value %h, want %h",
                                              m_axis_tdata, exp.value));
                if (m_axis_tlast !== exp.last_result)
                    report_mismatch($sformatf("last_result %b, want %b on %h",
                                              m_axis_tlast, exp.last_result, exp.value));
                if (m_axis_tuser !== exp.dropped)
                    report_mismatch($sformatf("dropped %b, want %b on %h",
                                              m_axis_tuser, exp.dropped, exp.value));
            end
        end
        if (rst_n && req_taken)
            sort_insert(isort_pkg::value_t'(s_axis_tdata), s_axis_tlast);
    end

    // Drive both handshake sides on the falling edge, ahead of the sampling edge.
    always @(negedge clk)
    begin : drive_requests
        sort_req_t req;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (!s_axis_tvalid || req_taken)
            begin
                if (pending_values.size() != 0
                    && !(pending_values[0].hold && expected_sorted.size() != 0)
                    && $urandom_range(99) >= src_idle_pct[pending_values[0].phase])
                begin
                    req = pending_values.pop_front();
                    cur_phase = req.phase;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= req.value;
                    s_axis_tlast  <= req.last_item;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= $urandom_range(99) >= snk_idle_pct[cur_phase];
        end
    end

    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin : run_test
        int n;
        int len;
        int big_len[3] = '{65, 64, 70};

        // single-value set
        push_req(32'sd0, 1'b1, 0, 1'b0);
        // extremes, duplicate minimum closing the set
        push_req(VAL_MAX, 1'b0, 0, 1'b0);
        push_req(VAL_MIN, 1'b0, 0, 1'b0);
        push_req(-32'sd1, 1'b0, 0, 1'b0);
        push_req(32'sd0, 1'b0, 0, 1'b0);
        push_req(32'sd1, 1'b0, 0, 1'b0);
        push_req(VAL_MIN, 1'b1, 0, 1'b0);
        // all equal
        push_req(32'sd3, 1'b0, 0, 1'b0);
        push_req(32'sd3, 1'b0, 0, 1'b0);
        push_req(32'sd3, 1'b1, 0, 1'b0);
        // descending, then ascending order of arrival
        push_req(32'sd4, 1'b0, 0, 1'b0);
        push_req(32'sd3, 1'b0, 0, 1'b0);
        push_req(32'sd2, 1'b0, 0, 1'b0);
        push_req(32'sd1, 1'b1, 0, 1'b0);
        push_req(-32'sd2, 1'b0, 0, 1'b0);
        push_req(-32'sd1, 1'b0, 0, 1'b0);
        push_req(32'sd0, 1'b0, 0, 1'b0);
        push_req(32'sd1, 1'b1, 0, 1'b0);

        // The random part of each phase opens with a large set: full plus closing value dropped,
        // exactly full, and overflow in the middle of the set.
        for (int ph = 0; ph < 3; ph++)
        begin
            queue_set(big_len[ph], ph, ph != 0);
            n = big_len[ph];
            while (n < PHASE_ITEMS)
            begin
                len = ($urandom_range(99) < 4) ? $urandom_range(70, 60)
                                               : $urandom_range(12, 1);
                queue_set(len, ph, 1'b0);
                n += len;
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_values.size() != 0 || s_axis_tvalid || expected_sorted.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 16) @(posedge clk);

        if (expected_sorted.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_sorted.size()));
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/isort_pkg.sv
hw/rtl/isort_cell.sv
hw/rtl/insertion_sorter_top.sv
hw/rtl/isort_check.sv
sim/tb_insertion_sorter_top.sv
